### hw/rtl/pn3d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_pkg: shared types and constants for the 3d fractal noise block
// fixed-point format, controller commands and the gradient function
// ----------------------------------------------------------------------------
package pn3d_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int TABLE_SIZE = 256;
	localparam int FX_W       = 24;
	localparam int ONE_FX     = 1 << FRAC_BITS;
	localparam int OUT_W      = 19;
	localparam int HASH_SLOTS = 14;

	typedef logic signed [FX_W-1:0] fx_t;

	localparam fx_t FX_ONE     = fx_t'(ONE_FX);
	localparam fx_t FX_TEN     = fx_t'(10 * ONE_FX);
	localparam fx_t FX_FIFTEEN = fx_t'(15 * ONE_FX);

	// last step index of the hash and lerp phases inside one octave
	localparam logic [3:0] HASH_LAST = 4'd14;
	localparam logic [3:0] LERP_LAST = 4'd8;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_LERP,
		ST_ACC,
		ST_DONE
	} state_t;

	// multiplier micro-ops
	typedef enum logic [3:0] {
		MO_NONE,
		MO_T2,
		MO_IN,
		MO_T3,
		MO_FADE,
		MO_E0,
		MO_E1,
		MO_E2,
		MO_E3,
		MO_F0,
		MO_F1,
		MO_N
	} mop_t;

	typedef struct packed {
		logic       tbl_we;
		logic       start;
		logic       rd_en;
		logic [3:0] rd_slot;
		mop_t       mop;
		logic [1:0] coord;
		logic       acc;
		logic [3:0] oct;
		logic       out_load;
	} dp_cmd_t;

	// gradient dot product; the low hash bits pick one of the cube-edge directions
	function automatic fx_t grad_fn(input logic [3:0] h, input fx_t x, input fx_t y,
		input fx_t z);
		fx_t u;
		fx_t v;
		u = (h < 4'd8) ? x : y;
		v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

endpackage

### hw/rtl/pn3d_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pn3d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/pn3d_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_dp: noise datapath
// permutation ram, hash registers, shared multiplier and octave accumulator
// ----------------------------------------------------------------------------
module pn3d_dp
	import pn3d_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  logic [7:0]         table_index,
	input  logic [7:0]         table_value,
	input  logic [31:0]        x_coord,
	input  logic [31:0]        y_coord,
	input  logic [31:0]        z_coord,
	output logic signed [OUT_W-1:0] fbm_value
);

	logic [31:0] xc_q, yc_q, zc_q;
	logic [7:0]  hash_q [HASH_SLOTS];
	logic        rd_pend_q;
	logic [3:0]  rd_slot_s1;
	logic [7:0]  rd_addr, rd_data;
	logic [7:0]  xi, yi, zi;
	fx_t         fx, fy, fz, x1, y1, z1, tsel;
	fx_t         grad [8];
	fx_t         t2_q, t3_q, in_q, u_q, v_q, w_q;
	fx_t         e0_q, e1_q, e2_q, e3_q, f0_q, f1_q, n_q, sum_q;
	fx_t         mul_a, mul_b, addend, mres;
	logic signed [2*FX_W-1:0] prod_s1;
	mop_t        mop_s1;
	logic [1:0]  coord_s1;

	assign xi = xc_q[FRAC_BITS+7:FRAC_BITS];
	assign yi = yc_q[FRAC_BITS+7:FRAC_BITS];
	assign zi = zc_q[FRAC_BITS+7:FRAC_BITS];
	assign fx = fx_t'({1'b0, xc_q[FRAC_BITS-1:0]});
	assign fy = fx_t'({1'b0, yc_q[FRAC_BITS-1:0]});
	assign fz = fx_t'({1'b0, zc_q[FRAC_BITS-1:0]});
	assign x1 = fx - FX_ONE;
	assign y1 = fy - FX_ONE;
	assign z1 = fz - FX_ONE;

	pn3d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_perm (
		.clk   (clk),
		.we    (cmd.tbl_we),
		.waddr (table_index),
		.wdata (table_value),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// hash chain addresses, each slot depends only on slots already captured
	always_comb begin
		case (cmd.rd_slot)
			4'd0:    rd_addr = xi;
			4'd1:    rd_addr = 8'(xi + 8'd1);
			4'd2:    rd_addr = 8'(hash_q[0] + yi);
			4'd3:    rd_addr = 8'(hash_q[0] + yi + 8'd1);
			4'd4:    rd_addr = 8'(hash_q[1] + yi);
			4'd5:    rd_addr = 8'(hash_q[1] + yi + 8'd1);
			4'd6:    rd_addr = 8'(hash_q[2] + zi);
			4'd7:    rd_addr = 8'(hash_q[2] + zi + 8'd1);
			4'd8:    rd_addr = 8'(hash_q[3] + zi);
			4'd9:    rd_addr = 8'(hash_q[3] + zi + 8'd1);
			4'd10:   rd_addr = 8'(hash_q[4] + zi);
			4'd11:   rd_addr = 8'(hash_q[4] + zi + 8'd1);
			4'd12:   rd_addr = 8'(hash_q[5] + zi);
			4'd13:   rd_addr = 8'(hash_q[5] + zi + 8'd1);
			default: rd_addr = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 1'b0;
			mop_s1    <= MO_NONE;
		end else begin
			rd_pend_q <= cmd.rd_en;
			mop_s1    <= cmd.mop;
		end
	end

	always_ff @(posedge clk) begin
		rd_slot_s1 <= cmd.rd_slot;
		if (rd_pend_q && rd_slot_s1 < 4'(HASH_SLOTS)) begin
			hash_q[rd_slot_s1] <= rd_data;
		end
	end

	// corner k: bit 2 selects x side, bit 1 y side, bit 0 z side
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			grad[k] = grad_fn(hash_q[6+k][3:0], (k[2] ? x1 : fx), (k[1] ? y1 : fy),
				(k[0] ? z1 : fz));
		end
	end

	always_comb begin
		case (cmd.coord)
			2'd0:    tsel = fx;
			2'd1:    tsel = fy;
			default: tsel = fz;
		endcase
	end

	always_comb begin
		case (cmd.mop)
			MO_T2: begin
				mul_a = tsel;
				mul_b = tsel;
			end
			MO_IN: begin
				mul_a = tsel;
				mul_b = (tsel <<< 2) + (tsel <<< 1) - FX_FIFTEEN;
			end
			MO_T3: begin
				mul_a = t2_q;
				mul_b = tsel;
			end
			MO_FADE: begin
				mul_a = t3_q;
				mul_b = in_q;
			end
			MO_E0: begin
				mul_a = u_q;
				mul_b = grad[4] - grad[0];
			end
			MO_E1: begin
				mul_a = u_q;
				mul_b = grad[6] - grad[2];
			end
			MO_E2: begin
				mul_a = u_q;
				mul_b = grad[5] - grad[1];
			end
			MO_E3: begin
				mul_a = u_q;
				mul_b = grad[7] - grad[3];
			end
			MO_F0: begin
				mul_a = v_q;
				mul_b = e1_q - e0_q;
			end
			MO_F1: begin
				mul_a = v_q;
				mul_b = e3_q - e2_q;
			end
			MO_N: begin
				mul_a = w_q;
				mul_b = f1_q - f0_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1  <= mul_a * mul_b;
		coord_s1 <= cmd.coord;
	end

	// writeback: floor of the product plus the lerp base, ten for the fade polynomial, else zero
	always_comb begin
		case (mop_s1)
			MO_IN:   addend = FX_TEN;
			MO_E0:   addend = grad[0];
			MO_E1:   addend = grad[2];
			MO_E2:   addend = grad[1];
			MO_E3:   addend = grad[3];
			MO_F0:   addend = e0_q;
			MO_F1:   addend = e2_q;
			MO_N:    addend = f0_q;
			default: addend = '0;
		endcase
		mres = fx_t'(prod_s1 >>> FRAC_BITS) + addend;
	end

	always_ff @(posedge clk) begin
		case (mop_s1)
			MO_T2:   t2_q <= mres;
			MO_IN:   in_q <= mres;
			MO_T3:   t3_q <= mres;
			MO_FADE: begin
				case (coord_s1)
					2'd0:    u_q <= mres;
					2'd1:    v_q <= mres;
					default: w_q <= mres;
				endcase
			end
			MO_E0:   e0_q <= mres;
			MO_E1:   e1_q <= mres;
			MO_E2:   e2_q <= mres;
			MO_E3:   e3_q <= mres;
			MO_F0:   f0_q <= mres;
			MO_F1:   f1_q <= mres;
			MO_N:    n_q  <= mres;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			xc_q  <= x_coord;
			yc_q  <= y_coord;
			zc_q  <= z_coord;
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_q + (n_q >>> cmd.oct);
			xc_q  <= {xc_q[30:0], 1'b0};
			yc_q  <= {yc_q[30:0], 1'b0};
			zc_q  <= {zc_q[30:0], 1'b0};
		end
		if (cmd.out_load) begin
			if (sum_q > fx_t'(262143)) begin
				fbm_value <= OUT_W'(262143);
			end else if (sum_q < fx_t'(-262144)) begin
				fbm_value <= OUT_W'(-262144);
			end else begin
				fbm_value <= sum_q[OUT_W-1:0];
			end
		end
	end

endmodule

### hw/rtl/pn3d_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn3d_ctrl: sequencer for loads and octave evaluation
// steps the datapath through hash, fade, lerp and accumulate per octave
// ----------------------------------------------------------------------------
module pn3d_ctrl
	import pn3d_pkg::*;
#(
	parameter int OCTAVE_MAX = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	output logic       out_valid,
	input  logic       out_ready,
	input  logic [3:0] octave_count,
	output dp_cmd_t    cmd
);

	localparam int OCT_LIM = (OCTAVE_MAX > 15) ? 15 : OCTAVE_MAX;

	state_t     state_q, state_d;
	logic [3:0] step_q, step_d;
	logic [3:0] oct_q, oct_d;
	logic [3:0] oct_n;
	logic       out_valid_q;

	assign oct_n     = (octave_count > 4'(OCT_LIM)) ? 4'(OCT_LIM) : octave_count;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			oct_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			oct_q   <= oct_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		oct_d    = oct_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.oct  = oct_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (command == CMD_LOAD) begin
						cmd.tbl_we = 1'b1;
					end else begin
						cmd.start = 1'b1;
						step_d    = '0;
						oct_d     = '0;
						state_d   = (oct_n == 4'd0) ? ST_DONE : ST_HASH;
					end
				end
			end
			ST_HASH: begin
				cmd.rd_en   = (step_q < HASH_LAST);
				cmd.rd_slot = step_q;
				// fade of x, y, z overlaps the hash reads, five steps each
				case (step_q)
					4'd0:  begin cmd.mop = MO_T2;   cmd.coord = 2'd0; end
					4'd1:  begin cmd.mop = MO_IN;   cmd.coord = 2'd0; end
					4'd2:  begin cmd.mop = MO_T3;   cmd.coord = 2'd0; end
					4'd4:  begin cmd.mop = MO_FADE; cmd.coord = 2'd0; end
					4'd5:  begin cmd.mop = MO_T2;   cmd.coord = 2'd1; end
					4'd6:  begin cmd.mop = MO_IN;   cmd.coord = 2'd1; end
					4'd7:  begin cmd.mop = MO_T3;   cmd.coord = 2'd1; end
					4'd9:  begin cmd.mop = MO_FADE; cmd.coord = 2'd1; end
					4'd10: begin cmd.mop = MO_T2;   cmd.coord = 2'd2; end
					4'd11: begin cmd.mop = MO_IN;   cmd.coord = 2'd2; end
					4'd12: begin cmd.mop = MO_T3;   cmd.coord = 2'd2; end
					4'd14: begin cmd.mop = MO_FADE; cmd.coord = 2'd2; end
					default: cmd.mop = MO_NONE;
				endcase
				if (step_q == HASH_LAST) begin
					step_d  = '0;
					state_d = ST_LERP;
				end else begin
					step_d = step_q + 4'd1;
				end
			end
			ST_LERP: begin
				case (step_q)
					4'd0:    cmd.mop = MO_E0;
					4'd1:    cmd.mop = MO_E1;
					4'd2:    cmd.mop = MO_E2;
					4'd3:    cmd.mop = MO_E3;
					4'd4:    cmd.mop = MO_F0;
					4'd5:    cmd.mop = MO_F1;
					4'd7:    cmd.mop = MO_N;
					default: cmd.mop = MO_NONE;
				endcase
				if (step_q == LERP_LAST) begin
					step_d  = '0;
					state_d = ST_ACC;
				end else begin
					step_d = step_q + 4'd1;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				if (5'(oct_q) + 5'd1 == 5'(oct_n)) begin
					state_d = ST_DONE;
				end else begin
					oct_d   = oct_q + 4'd1;
					state_d = ST_HASH;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### hw/rtl/perlin_noise_3d_octaves_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_3d_octaves_top: fractal 3d gradient noise engine
// octave sum of improved gradient noise over a loadable permutation table
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready): one transfer carries a command.
//   command load writes table_value into permutation entry table_index and
//   produces no result. command evaluate takes a q16.16 point
//   and produces one fbm_value transfer in q2.16, saturated.
//   output channel (out_valid / out_ready): the result sits in an output
//   register, so the next item is accepted while a result waits.
//   sequence: for each octave (octave_count clamped to OCTAVE_MAX), an
//   evaluate does the hash reads through the single table read port with
//   the fades overlapped, then the seven lerps on the shared multiplier,
//   then the accumulate; the sum then goes to the output register.
//   one item is in work at a time; the multiplier and the table port set it.
//   a stalled receiver holds the finished result in the datapath until the
//   output register frees up; no further input is taken meanwhile.
//   reset clears the sequencer and sets octave_count to 1. the table has no
//   reset and must be loaded before evaluation.
//   apb register 0 (byte address 0): octave_count, 4 bits.
// ----------------------------------------------------------------------------
module perlin_noise_3d_octaves_top
	import pn3d_pkg::*;
#(
	parameter int OCTAVE_MAX = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// apb register port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// input channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    command,
	input  logic [7:0]              table_index,
	input  logic [7:0]              table_value,
	input  logic signed [31:0]      x_coord,
	input  logic signed [31:0]      y_coord,
	input  logic signed [31:0]      z_coord,
	// output channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] fbm_value
);

	logic [3:0] octave_count_q;
	dp_cmd_t    cmd;

	// register file: one register, decoded at byte addresses 0 to 3; paddr[2] flags addresses past it
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= 4'd1;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			octave_count_q <= pwdata[3:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (!paddr[2]) begin
			prdata = {28'd0, octave_count_q};
		end
	end

	// sequencer
	pn3d_ctrl #(.OCTAVE_MAX(OCTAVE_MAX)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.octave_count (octave_count_q),
		.cmd          (cmd)
	);

	// table, multiplier and accumulator
	pn3d_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.table_index (table_index),
		.table_value (table_value),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.z_coord     (z_coord),
		.fbm_value   (fbm_value)
	);

endmodule
